/* src/sbls_pkg.sv */
// ----------------------------------------------------------------------------
// sbls_pkg
// shared types, constants and helpers of the stereo block level meter
// ----------------------------------------------------------------------------
package sbls_pkg;

	localparam int SAMPLE_WIDTH     = 16;
	localparam int MAG_WIDTH        = 16;
	localparam int SQ_WIDTH         = 31;
	localparam int RATE_WIDTH       = 20;
	localparam int FRAME_WIDTH      = 17;
	localparam int ENERGY_WIDTH     = 47;
	localparam int COUNT_WIDTH      = 17;
	localparam int BLOCK_WIDTH      = 32;
	localparam int CFG_INDEX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH   = 20;
	localparam int IN_TDATA_WIDTH   = 56;
	localparam int OUT_TDATA_WIDTH  = 264;

	localparam logic [FRAME_WIDTH-1:0] MAX_BLOCK_FRAMES = 17'd65536;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAMES_PER_BLOCK = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_LEVEL_THR   = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FULL_SCALE_THR   = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_VALID_RATE   = 2'd3;

	localparam logic [FRAME_WIDTH-1:0] RST_FRAMES_PER_BLOCK = 17'd4096;
	localparam logic [MAG_WIDTH-1:0]   RST_HIGH_LEVEL_THR   = 16'd29204;
	localparam logic [MAG_WIDTH-1:0]   RST_FULL_SCALE_THR   = 16'd32760;
	localparam logic [RATE_WIDTH-1:0]  RST_MIN_VALID_RATE   = 20'd8000;

	typedef struct packed {
		logic [FRAME_WIDTH-1:0] limit;
		logic [MAG_WIDTH-1:0]   high_thr;
		logic [MAG_WIDTH-1:0]   full_thr;
		logic [RATE_WIDTH-1:0]  min_rate;
	} cfg_t;

	typedef struct packed {
		logic [MAG_WIDTH-1:0] mag;
		logic [SQ_WIDTH-1:0]  sq;
		logic                 loud;
		logic                 clip;
	} chan_t;

	typedef struct packed {
		chan_t                 left;
		chan_t                 right;
		logic [RATE_WIDTH-1:0] rate;
		logic                  rate_ok;
		logic                  discard;
	} frame_t;

	typedef struct packed {
		logic [RATE_WIDTH-1:0]   block_rate;
		logic [COUNT_WIDTH-1:0]  clip_count_right;
		logic [COUNT_WIDTH-1:0]  clip_count_left;
		logic [COUNT_WIDTH-1:0]  loud_count_right;
		logic [COUNT_WIDTH-1:0]  loud_count_left;
		logic [ENERGY_WIDTH-1:0] energy_right;
		logic [ENERGY_WIDTH-1:0] energy_left;
		logic [MAG_WIDTH-1:0]    peak_right;
		logic [MAG_WIDTH-1:0]    peak_left;
		logic [FRAME_WIDTH-1:0]  frames_in_block;
		logic [BLOCK_WIDTH-1:0]  block_number;
	} rec_t;

	// zero acts as one, oversized values saturate
	function automatic logic [FRAME_WIDTH-1:0] clamp_limit(input logic [FRAME_WIDTH-1:0] v);
		logic [FRAME_WIDTH-1:0] r;
		r = v;
		if (v == '0) begin
			r = FRAME_WIDTH'(1);
		end else if (v > MAX_BLOCK_FRAMES) begin
			r = MAX_BLOCK_FRAMES;
		end
		return r;
	endfunction

	function automatic logic [MAG_WIDTH-1:0] magnitude(input logic signed [SAMPLE_WIDTH-1:0] s);
		logic [MAG_WIDTH-1:0] r;
		r = s[SAMPLE_WIDTH-1] ? MAG_WIDTH'(~s + 1'b1) : MAG_WIDTH'(s);
		return r;
	endfunction

endpackage

/* src/sbls_cfg.sv */
// ----------------------------------------------------------------------------
// sbls_cfg
// configuration registers, block length kept in its clamped form
// ----------------------------------------------------------------------------
module sbls_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sbls_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [sbls_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	output sbls_pkg::cfg_t                        cfg
);

	sbls_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit    <= sbls_pkg::clamp_limit(sbls_pkg::RST_FRAMES_PER_BLOCK);
			cfg_q.high_thr <= sbls_pkg::RST_HIGH_LEVEL_THR;
			cfg_q.full_thr <= sbls_pkg::RST_FULL_SCALE_THR;
			cfg_q.min_rate <= sbls_pkg::RST_MIN_VALID_RATE;
		end else if (cfg_we) begin
			case (cfg_index)
				sbls_pkg::REG_FRAMES_PER_BLOCK: begin
					cfg_q.limit <= sbls_pkg::clamp_limit(cfg_data[sbls_pkg::FRAME_WIDTH-1:0]);
				end
				sbls_pkg::REG_HIGH_LEVEL_THR: begin
					cfg_q.high_thr <= cfg_data[sbls_pkg::MAG_WIDTH-1:0];
				end
				sbls_pkg::REG_FULL_SCALE_THR: begin
					cfg_q.full_thr <= cfg_data[sbls_pkg::MAG_WIDTH-1:0];
				end
				sbls_pkg::REG_MIN_VALID_RATE: begin
					cfg_q.min_rate <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/sbls_front.sv */
// ----------------------------------------------------------------------------
// sbls_front
// input register, then magnitude, square and threshold flags per channel
// ----------------------------------------------------------------------------
module sbls_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sbls_pkg::cfg_t                       cfg,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [sbls_pkg::SAMPLE_WIDTH-1:0] in_left,
	input  logic signed [sbls_pkg::SAMPLE_WIDTH-1:0] in_right,
	input  logic [sbls_pkg::RATE_WIDTH-1:0]      in_rate,
	input  logic                                 in_discard,
	output logic                                 frm_valid,
	input  logic                                 frm_ready,
	output sbls_pkg::frame_t                     frm
);

	logic                                   valid_s1;
	logic signed [sbls_pkg::SAMPLE_WIDTH-1:0] left_s1;
	logic signed [sbls_pkg::SAMPLE_WIDTH-1:0] right_s1;
	logic [sbls_pkg::RATE_WIDTH-1:0]        rate_s1;
	logic                                   discard_s1;

	logic             valid_s2;
	sbls_pkg::frame_t frm_s2;
	sbls_pkg::frame_t frm_d;
	logic             s2_ready;
	logic             s1_ready;
	logic [2*sbls_pkg::MAG_WIDTH-1:0] sq_l;
	logic [2*sbls_pkg::MAG_WIDTH-1:0] sq_r;

	assign s2_ready = !valid_s2 || frm_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_ready = s1_ready;

	always_comb begin
		frm_d.left.mag  = sbls_pkg::magnitude(left_s1);
		frm_d.right.mag = sbls_pkg::magnitude(right_s1);
		sq_l = frm_d.left.mag * frm_d.left.mag;
		sq_r = frm_d.right.mag * frm_d.right.mag;
		frm_d.left.sq    = sq_l[sbls_pkg::SQ_WIDTH-1:0];
		frm_d.right.sq   = sq_r[sbls_pkg::SQ_WIDTH-1:0];
		frm_d.left.loud  = frm_d.left.mag >= cfg.high_thr;
		frm_d.right.loud = frm_d.right.mag >= cfg.high_thr;
		frm_d.left.clip  = frm_d.left.mag >= cfg.full_thr;
		frm_d.right.clip = frm_d.right.mag >= cfg.full_thr;
		frm_d.rate       = rate_s1;
		frm_d.rate_ok    = rate_s1 >= cfg.min_rate;
		frm_d.discard    = discard_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			left_s1    <= in_left;
			right_s1   <= in_right;
			rate_s1    <= in_rate;
			discard_s1 <= in_discard;
		end
		if (s2_ready && valid_s1) begin
			frm_s2 <= frm_d;
		end
	end

	assign frm_valid = valid_s2;
	assign frm       = frm_s2;

endmodule

/* src/sbls_accum.sv */
// ----------------------------------------------------------------------------
// sbls_accum
// per-block statistics, block completion and result register
// ----------------------------------------------------------------------------
module sbls_accum (
	input  logic             clk,
	input  logic             arst_n,
	input  sbls_pkg::cfg_t   cfg,
	input  logic             frm_valid,
	output logic             frm_ready,
	input  sbls_pkg::frame_t frm,
	output logic             rec_valid,
	input  logic             rec_ready,
	output sbls_pkg::rec_t   rec
);

	logic [sbls_pkg::BLOCK_WIDTH-1:0]  block_cnt_q;
	logic [sbls_pkg::FRAME_WIDTH-1:0]  frame_cnt_q;
	logic [sbls_pkg::MAG_WIDTH-1:0]    peak_l_q, peak_r_q;
	logic [sbls_pkg::ENERGY_WIDTH-1:0] energy_l_q, energy_r_q;
	logic [sbls_pkg::COUNT_WIDTH-1:0]  loud_l_q, loud_r_q;
	logic [sbls_pkg::COUNT_WIDTH-1:0]  clip_l_q, clip_r_q;
	logic [sbls_pkg::RATE_WIDTH-1:0]   rate_q;

	logic                              out_valid_q;
	sbls_pkg::rec_t                    out_q;

	sbls_pkg::rec_t                    nxt;
	logic                              done;
	logic                              out_free;
	logic                              fire;

	// discard clears everything before the frame is counted
	always_comb begin
		if (frm.discard) begin
			nxt = '0;
		end else begin
			nxt.block_number     = block_cnt_q;
			nxt.frames_in_block  = frame_cnt_q;
			nxt.peak_left        = peak_l_q;
			nxt.peak_right       = peak_r_q;
			nxt.energy_left      = energy_l_q;
			nxt.energy_right     = energy_r_q;
			nxt.loud_count_left  = loud_l_q;
			nxt.loud_count_right = loud_r_q;
			nxt.clip_count_left  = clip_l_q;
			nxt.clip_count_right = clip_r_q;
			nxt.block_rate       = rate_q;
		end
		if (frm.rate_ok) begin
			nxt.block_rate = frm.rate;
		end
		if (frm.left.mag > nxt.peak_left) begin
			nxt.peak_left = frm.left.mag;
		end
		if (frm.right.mag > nxt.peak_right) begin
			nxt.peak_right = frm.right.mag;
		end
		nxt.energy_left  = nxt.energy_left
			+ sbls_pkg::ENERGY_WIDTH'(frm.left.sq);
		nxt.energy_right = nxt.energy_right
			+ sbls_pkg::ENERGY_WIDTH'(frm.right.sq);
		nxt.loud_count_left  = nxt.loud_count_left
			+ sbls_pkg::COUNT_WIDTH'(frm.left.loud);
		nxt.loud_count_right = nxt.loud_count_right
			+ sbls_pkg::COUNT_WIDTH'(frm.right.loud);
		nxt.clip_count_left  = nxt.clip_count_left
			+ sbls_pkg::COUNT_WIDTH'(frm.left.clip);
		nxt.clip_count_right = nxt.clip_count_right
			+ sbls_pkg::COUNT_WIDTH'(frm.right.clip);
		nxt.frames_in_block  = nxt.frames_in_block + 1'b1;
		done = nxt.frames_in_block >= cfg.limit;
	end

	assign out_free  = !out_valid_q || rec_ready;
	assign fire      = frm_valid && (!done || out_free);
	assign frm_ready = !frm_valid || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_cnt_q <= '0;
			frame_cnt_q <= '0;
			peak_l_q    <= '0;
			peak_r_q    <= '0;
			energy_l_q  <= '0;
			energy_r_q  <= '0;
			loud_l_q    <= '0;
			loud_r_q    <= '0;
			clip_l_q    <= '0;
			clip_r_q    <= '0;
			rate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rate_q <= nxt.block_rate;
				if (done) begin
					block_cnt_q <= nxt.block_number + 1'b1;
					frame_cnt_q <= '0;
					peak_l_q    <= '0;
					peak_r_q    <= '0;
					energy_l_q  <= '0;
					energy_r_q  <= '0;
					loud_l_q    <= '0;
					loud_r_q    <= '0;
					clip_l_q    <= '0;
					clip_r_q    <= '0;
				end else begin
					block_cnt_q <= nxt.block_number;
					frame_cnt_q <= nxt.frames_in_block;
					peak_l_q    <= nxt.peak_left;
					peak_r_q    <= nxt.peak_right;
					energy_l_q  <= nxt.energy_left;
					energy_r_q  <= nxt.energy_right;
					loud_l_q    <= nxt.loud_count_left;
					loud_r_q    <= nxt.loud_count_right;
					clip_l_q    <= nxt.clip_count_left;
					clip_r_q    <= nxt.clip_count_right;
				end
			end
			if (fire && done) begin
				out_valid_q <= 1'b1;
			end else if (rec_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && done) begin
			out_q <= nxt;
		end
	end

	assign rec_valid = out_valid_q;
	assign rec       = out_q;

endmodule

/* src/stereo_block_level_stats.sv */
// ----------------------------------------------------------------------------
// stereo_block_level_stats
// stereo peak, energy and threshold-count meter emitting one record per block
// ----------------------------------------------------------------------------
// a block record is registered for output once its closing frame has passed the input and frame registers
// throughput: one frame per cycle unless the output stalls, set by the combinational statistics update
// a waiting record stalls the input only at a frame that closes the next block
// reset clears all statistics, block number, latched rate and pipeline valids
// configuration returns to its documented defaults on reset
// ----------------------------------------------------------------------------
module stereo_block_level_stats (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// left_sample, right_sample, sample_rate, zero pad
	input  logic [sbls_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
	// discard_first
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// block_number, frames_in_block, peak_left, peak_right, energy_left,
	// energy_right, loud_count_left, loud_count_right, clip_count_left,
	// clip_count_right, block_rate, zero pad
	output logic [sbls_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
	input  logic                                   cfg_we,
	input  logic [sbls_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [sbls_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

	sbls_pkg::cfg_t   cfg;
	logic             frm_valid;
	logic             frm_ready;
	sbls_pkg::frame_t frm;
	sbls_pkg::rec_t   rec;

	sbls_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbls_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_left    (s_axis_tdata[15:0]),
		.in_right   (s_axis_tdata[31:16]),
		.in_rate    (s_axis_tdata[51:32]),
		.in_discard (s_axis_tuser),
		.frm_valid  (frm_valid),
		.frm_ready  (frm_ready),
		.frm        (frm)
	);

	sbls_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm),
		.rec_valid (m_axis_tvalid),
		.rec_ready (m_axis_tready),
		.rec       (rec)
	);

	assign m_axis_tdata = {1'b0, rec};

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// stereo block level meter: frames go in on the input stream, block records are
// predicted frame by frame and checked field by field as they leave the output
// stream, under several register settings, random stalls and one long backlog
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sbls_pkg::*;

	class block_stats_scoreboard;
		logic [FRAME_WIDTH-1:0]  frames_per_block;
		logic [MAG_WIDTH-1:0]    loud_thr;
		logic [MAG_WIDTH-1:0]    clip_thr;
		logic [RATE_WIDTH-1:0]   rate_floor;
		logic [BLOCK_WIDTH-1:0]  block_no;
		logic [20:0]             frames_seen;
		logic [MAG_WIDTH-1:0]    peak [2];
		logic [ENERGY_WIDTH-1:0] energy [2];
		logic [COUNT_WIDTH-1:0]  loud [2];
		logic [COUNT_WIDTH-1:0]  clip [2];
		logic [RATE_WIDTH-1:0]   held_rate;
		rec_t                    pending_records[$];
		int                      mismatches;

		function new();
			frames_per_block = RST_FRAMES_PER_BLOCK;
			loud_thr = RST_HIGH_LEVEL_THR;
			clip_thr = RST_FULL_SCALE_THR;
			rate_floor = RST_MIN_VALID_RATE;
			block_no = '0;
			held_rate = '0;
			mismatches = 0;
			clear_stats();
		endfunction

		function void clear_stats();
			frames_seen = '0;
			for (int c = 0; c < 2; c++) begin
				peak[c] = '0;
				energy[c] = '0;
				loud[c] = '0;
				clip[c] = '0;
			end
		endfunction

		function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
			case (idx)
				REG_FRAMES_PER_BLOCK: frames_per_block = val[FRAME_WIDTH-1:0];
				REG_HIGH_LEVEL_THR: loud_thr = val[MAG_WIDTH-1:0];
				REG_FULL_SCALE_THR: clip_thr = val[MAG_WIDTH-1:0];
				REG_MIN_VALID_RATE: rate_floor = val[RATE_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		// one accepted frame request
		function void note_frame(logic signed [SAMPLE_WIDTH-1:0] l, logic signed [SAMPLE_WIDTH-1:0] r,
				logic [RATE_WIDTH-1:0] rate, logic disc);
			logic [FRAME_WIDTH-1:0] limit;
			int mag;
			rec_t rec;
			if (disc) begin
				block_no = '0;
				held_rate = '0;
				clear_stats();
			end
			if (rate >= rate_floor) begin
				held_rate = rate;
			end
			for (int c = 0; c < 2; c++) begin
				mag = (c == 0) ? int'(l) : int'(r);
				if (mag < 0) begin
					mag = -mag;
				end
				if (mag > int'(peak[c])) begin
					peak[c] = MAG_WIDTH'(mag);
				end
				energy[c] = energy[c] + ENERGY_WIDTH'(mag * mag);
				if (mag >= int'(loud_thr)) begin
					loud[c] = loud[c] + 1'b1;
				end
				if (mag >= int'(clip_thr)) begin
					clip[c] = clip[c] + 1'b1;
				end
			end
			frames_seen = frames_seen + 21'd1;
			limit = frames_per_block;
			if (limit == '0) begin
				limit = FRAME_WIDTH'(1);
			end else if (limit > MAX_BLOCK_FRAMES) begin
				limit = MAX_BLOCK_FRAMES;
			end
			if (frames_seen >= 21'(limit)) begin
				rec.block_number = block_no;
				rec.frames_in_block = frames_seen[FRAME_WIDTH-1:0];
				rec.peak_left = peak[0];
				rec.peak_right = peak[1];
				rec.energy_left = energy[0];
				rec.energy_right = energy[1];
				rec.loud_count_left = loud[0];
				rec.loud_count_right = loud[1];
				rec.clip_count_left = clip[0];
				rec.clip_count_right = clip[1];
				rec.block_rate = held_rate;
				pending_records.push_back(rec);
				block_no = block_no + 1'b1;
				clear_stats();
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t %s: expected %0d, got %0d", $realtime, name, want, got);
				end
			end
		endfunction

		function void check_record(rec_t got);
			rec_t want;
			if (pending_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t block record with none pending: %h", $realtime, got);
				end
				return;
			end
			want = pending_records.pop_front();
			compare_field("block_number", want.block_number, got.block_number);
			compare_field("frames_in_block", want.frames_in_block, got.frames_in_block);
			compare_field("peak_left", want.peak_left, got.peak_left);
			compare_field("peak_right", want.peak_right, got.peak_right);
			compare_field("energy_left", want.energy_left, got.energy_left);
			compare_field("energy_right", want.energy_right, got.energy_right);
			compare_field("loud_count_left", want.loud_count_left, got.loud_count_left);
			compare_field("loud_count_right", want.loud_count_right, got.loud_count_right);
			compare_field("clip_count_left", want.clip_count_left, got.clip_count_left);
			compare_field("clip_count_right", want.clip_count_right, got.clip_count_right);
			compare_field("block_rate", want.block_rate, got.block_rate);
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [IN_TDATA_WIDTH-1:0]     s_axis_tdata;
	logic                          s_axis_tuser;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [OUT_TDATA_WIDTH-1:0]    m_axis_tdata;
	logic                          cfg_we;
	logic [CFG_INDEX_WIDTH-1:0]    cfg_index;
	logic [CFG_DATA_WIDTH-1:0]     cfg_data;

	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	block_stats_scoreboard sb = new();
	int corner_vals [6] = '{-32768, -32767, -1, 0, 1, 32767};

	stereo_block_level_stats dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sb.note_frame(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[51:32], s_axis_tuser);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_record(rec_t'(m_axis_tdata[$bits(rec_t)-1:0]));
		end
	end

	// record sink: random stalls, plus one long hold-off on demand
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (80) @(negedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
		int m;
		case ($urandom_range(0, 5))
			0: return SAMPLE_WIDTH'(corner_vals[$urandom_range(0, 5)]);
			1: m = int'(sb.loud_thr) + int'($urandom_range(0, 2)) - 1;
			2: m = int'(sb.clip_thr) + int'($urandom_range(0, 2)) - 1;
			default: return SAMPLE_WIDTH'($urandom_range(0, 65535));
		endcase
		if (m < 0) begin
			m = 0;
		end else if (m > 32768) begin
			m = 32768;
		end
		if (m == 32768 || $urandom_range(0, 1) == 1) begin
			m = -m;
		end
		return SAMPLE_WIDTH'(m);
	endfunction

	function automatic logic [RATE_WIDTH-1:0] pick_rate();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? '1 : '0;
			1: return sb.rate_floor + RATE_WIDTH'($urandom_range(0, 2)) - 1'b1;
			2: return $urandom_range(0, 1) ? 20'd44100 : 20'd48000;
			default: return RATE_WIDTH'($urandom_range(0, 20'hFFFFF));
		endcase
	endfunction

	function automatic int pick_thr();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 32768;
			2: return 29204 + int'($urandom_range(0, 3600));
			default: return int'($urandom_range(0, 32768));
		endcase
	endfunction

	task automatic send_frame(input logic [SAMPLE_WIDTH-1:0] l, input logic [SAMPLE_WIDTH-1:0] r,
			input logic [RATE_WIDTH-1:0] rate, input logic disc);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, rate, r, l};
		s_axis_tuser <= disc;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// waits until no record is pending and the hold-off is over, then lets the pipeline drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_records.size() != 0 || hold_req) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_WIDTH'(val);
		sb.write_reg(idx, CFG_DATA_WIDTH'(val));
		@(negedge clk);
	endtask

	task automatic set_config(input int fpb, input int hi, input int full, input int floor);
		write_reg(REG_FRAMES_PER_BLOCK, fpb);
		write_reg(REG_HIGH_LEVEL_THR, hi);
		write_reg(REG_FULL_SCALE_THR, full);
		write_reg(REG_MIN_VALID_RATE, floor);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_frame(pick_sample(), pick_sample(), pick_rate(), $urandom_range(0, 19) == 0);
		end
	endtask

	initial begin
		int fpb;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values of all registers: a partial default-length block
		for (int i = 0; i < 60; i++) begin
			send_frame(pick_sample(), pick_sample(), pick_rate(), 1'b0);
		end
		wait_idle();

		// one frame per block closes the default block, then sample extremes,
		// rate floor edges, discard
		set_config(1, 32768, 32767, 8000);
		send_frame(16'h8000, 16'h7fff, 20'd8000, 1'b0);
		send_frame(16'h7fff, 16'h8000, 20'd7999, 1'b0);
		send_frame(16'h0000, 16'hffff, 20'd0, 1'b0);
		send_frame(16'h0001, 16'h8001, 20'hFFFFF, 1'b1);
		send_frame(16'hffff, 16'h0000, 20'd8000, 1'b0);
		wait_idle();

		// zero block length, zero thresholds count every sample
		set_config(0, 0, 0, 0);
		send_frame(16'h0000, 16'h0000, 20'd0, 1'b0);
		send_frame(16'h8000, 16'h8000, 20'hFFFFF, 1'b0);
		send_frame(16'h7fff, 16'h0001, 20'd5, 1'b1);
		wait_idle();

		// discard in the middle of a block, top rate floor
		set_config(3, 1, 32768, 20'hFFFFF);
		send_frame(16'h0001, 16'hffff, 20'hFFFFF, 1'b0);
		send_frame(16'h8000, 16'h4000, 20'hFFFFE, 1'b0);
		send_frame(16'h1234, 16'h8000, 20'hFFFFE, 1'b1);
		send_frame(16'h0000, 16'h7fff, 20'hFFFFF, 1'b0);
		send_frame(16'hc000, 16'h0002, 20'd0, 1'b0);
		send_frame(16'h0000, 16'h0000, 20'd0, 1'b0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case ($urandom_range(0, 3))
				0: fpb = 0;
				1: fpb = int'($urandom_range(9, 40));
				default: fpb = int'($urandom_range(1, 8));
			endcase
			if (p == 2) begin
				fpb = 1;
			end
			set_config(fpb, pick_thr(), pick_thr(),
				$urandom_range(0, 1) ? 8000 : int'($urandom_range(0, 20'hFFFFF)));
			if (p == 2) begin
				hold_req = 1'b1;
			end
			run_random(60);
			wait_idle();
		end

		// oversized block length saturates: no block closes early
		quiet = 1'b1;
		set_config(131071, 0, 32768, 0);
		for (int i = 0; i < 50; i++) begin
			send_frame(16'h8000, pick_sample(), pick_rate(), i == 0);
		end
		wait_idle();

		// a short length then closes the long block
		set_config(2, 0, 32768, 0);
		send_frame(16'h8000, 16'h8000, 20'd48000, 1'b0);
		wait_idle();

		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
